FILE: sv/rc_channel_trim_and_speed_limit_assert.svh
// ----------------------------------------------------------------------------
// rc channel trim and speed limit assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_TRIM_AND_SPEED_LIMIT_ASSERT_SVH
`define RC_CHANNEL_TRIM_AND_SPEED_LIMIT_ASSERT_SVH

`ifndef SYNTH

// same cycle implication
`define RCTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next cycle implication
`define RCTS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next cycle implication failed");

`else

`define RCTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define RCTS_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/rcts_pkg.sv
// ----------------------------------------------------------------------------
// rcts_pkg
// widths, register codes, reset values and shared types of the channel
// trim and speed limit pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcts_pkg;

  localparam int CH_W       = 11;
  localparam int MV_W       = 16;
  localparam int Q_W        = 17;
  localparam int Q_FRAC     = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int DIV_STAGE_BITS_DEF = 4;

  localparam logic [Q_W-1:0]         Q16_ONE    = Q_W'(65536);
  localparam logic [PCT_W-1:0]       PCT_SCALE  = PCT_W'(100);
  localparam logic [Q_W+PCT_W-1:0]   PCT_ROUND  = (Q_W+PCT_W)'(32768);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRAWL_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_THRESH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRAWL_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LIMIT     = 3'd6;

  localparam logic [CH_W-1:0] RST_CHANNEL_MIN    = CH_W'(172);
  localparam logic [CH_W-1:0] RST_CHANNEL_CENTER = CH_W'(992);
  localparam logic [CH_W-1:0] RST_CHANNEL_MAX    = CH_W'(1811);
  localparam logic [MV_W-1:0] RST_CRAWL_THRESH   = MV_W'(6000);
  localparam logic [MV_W-1:0] RST_WARN_THRESH    = MV_W'(7000);
  localparam logic [Q_W-1:0]  RST_CRAWL_LIMIT    = Q_W'(6554);
  localparam logic [Q_W-1:0]  RST_TRIM_LIMIT     = Q_W'(13107);

  typedef enum logic [1:0] {
    LIM_ZERO,
    LIM_FULL,
    LIM_DIV
  } lim_mode_t;

  typedef struct packed {
    logic            armed;
    logic            crawl;
    logic            warn;
    logic [CH_W-1:0] steer;
    logic [CH_W-1:0] throttle;
    logic [CH_W-1:0] s_trim;
    logic [CH_W-1:0] t_trim;
    logic [CH_W-1:0] trim_mag;
    logic            trim_neg;
    lim_mode_t       mode;
  } side_t;

  typedef struct packed {
    logic [CH_W-1:0]   rem;
    logic [CH_W-1:0]   den;
    logic [Q_FRAC-1:0] quot;
  } div_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [CH_W+3:0] v,
                                                input logic [CH_W-1:0] lo,
                                                input logic [CH_W-1:0] hi);
    logic signed [CH_W+3:0] r;
    r = v;
    if (r < $signed({4'b0000, lo})) r = $signed({4'b0000, lo});
    if (r > $signed({4'b0000, hi})) r = $signed({4'b0000, hi});
    return r[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rcts_front.sv
// ----------------------------------------------------------------------------
// rcts_front
// first stage: registers the item, sorts out the speed limit case,
// bounds the steering trim offset and sets the battery flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcts_front import rcts_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [CH_W-1:0] steer_value,
  input  wire logic [CH_W-1:0] throttle_value,
  input  wire logic [CH_W-1:0] steer_trim,
  input  wire logic [CH_W-1:0] throttle_trim,
  input  wire logic [MV_W-1:0] battery_mv,
  input  wire logic            arm_switch,
  input  wire logic [CH_W-1:0] channel_min,
  input  wire logic [CH_W-1:0] channel_center,
  input  wire logic [CH_W-1:0] channel_max,
  input  wire logic [MV_W-1:0] crawl_threshold_mv,
  input  wire logic [MV_W-1:0] warn_threshold_mv,
  output logic                 valid,
  output side_t                side,
  output div_t                 div
);

  side_t side_next;
  div_t  div_next;

  always_comb begin
    logic [CH_W-1:0] trim_abs;
    logic [CH_W-1:0] upper_span;
    logic [CH_W-1:0] full_span;
    logic [CH_W-1:0] trim_dev;
    logic            batt_known;

    batt_known = battery_mv != '0;

    side_next.armed    = arm_switch;
    side_next.crawl    = batt_known && (battery_mv < crawl_threshold_mv);
    side_next.warn     = batt_known && (battery_mv < warn_threshold_mv);
    side_next.steer    = steer_value;
    side_next.throttle = throttle_value;
    side_next.s_trim   = steer_trim;
    side_next.t_trim   = throttle_trim;

    // steering trim offset, bounded to the upper half span
    side_next.trim_neg = steer_trim < channel_center;
    trim_abs   = side_next.trim_neg ? (channel_center - steer_trim)
                                    : (steer_trim - channel_center);
    upper_span = channel_max - channel_center;
    if (channel_max > channel_center) begin
      side_next.trim_mag = (trim_abs > upper_span) ? upper_span : trim_abs;
    end else begin
      side_next.trim_mag = '0;
    end

    // speed limit: fixed ends, or a fraction left to the divider
    full_span    = channel_max - channel_min;
    trim_dev     = throttle_trim - channel_min;
    div_next.rem  = '0;
    div_next.den  = CH_W'(1);
    div_next.quot = '0;
    if (channel_max <= channel_min) begin
      if (throttle_trim >= channel_min) begin
        side_next.mode = LIM_FULL;
      end else begin
        side_next.mode = LIM_ZERO;
      end
    end else if (throttle_trim <= channel_min) begin
      side_next.mode = LIM_ZERO;
    end else if (trim_dev >= full_span) begin
      side_next.mode = LIM_FULL;
    end else begin
      side_next.mode = LIM_DIV;
      div_next.rem   = trim_dev;
      div_next.den   = full_span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    side <= side_next;
    div  <= div_next;
  end

endmodule

`default_nettype wire

FILE: sv/rcts_div_stage.sv
// ----------------------------------------------------------------------------
// rcts_div_stage
// one stage of the restoring divider for the speed limit fraction,
// STAGE_BITS quotient bits per stage, item fields ride along
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_channel_trim_and_speed_limit_assert.svh"

module rcts_div_stage import rcts_pkg::*; #(
  parameter int STAGE_BITS = DIV_STAGE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  valid_in,
  input  wire side_t side_in,
  input  wire div_t  div_in,
  output logic       valid_out,
  output side_t      side_out,
  output div_t       div_out
);

  div_t div_next;

  always_comb begin
    logic [CH_W:0]     r2;
    logic [CH_W-1:0]   r;
    logic [Q_FRAC-1:0] q;
    r = div_in.rem;
    q = div_in.quot;
    for (int i = 0; i < STAGE_BITS; i++) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, div_in.den}) begin
        r = CH_W'(r2 - {1'b0, div_in.den});
        q = {q[Q_FRAC-2:0], 1'b1};
      end else begin
        r = r2[CH_W-1:0];
        q = {q[Q_FRAC-2:0], 1'b0};
      end
    end
    div_next.rem  = r;
    div_next.den  = div_in.den;
    div_next.quot = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    side_out <= side_in;
    div_out  <= div_next;
  end

  `RCTS_ASSERT_IMP(a_rem_below_den, clk, rst, valid_out, div_out.rem < div_out.den)
  `RCTS_ASSERT_NXT(a_valid_moves, clk, rst, valid_in, valid_out)

endmodule

`default_nettype wire

FILE: sv/rcts_back.sv
// ----------------------------------------------------------------------------
// rcts_back
// last two stages: speed limit select and products, then flooring,
// percent rounding, clamping, disarm override and the registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_channel_trim_and_speed_limit_assert.svh"

module rcts_back import rcts_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid_in,
  input  wire side_t           side_in,
  input  wire div_t            div_in,
  input  wire logic [CH_W-1:0] channel_min,
  input  wire logic [CH_W-1:0] channel_center,
  input  wire logic [CH_W-1:0] channel_max,
  input  wire logic [Q_W-1:0]  crawl_limit_q16,
  input  wire logic [Q_W-1:0]  trim_limit_q16,
  output logic                 done,
  output logic [CH_W-1:0]      out_steer,
  output logic [CH_W-1:0]      out_throttle,
  output logic [CH_W-1:0]      out_arm,
  output logic [CH_W-1:0]      out_steer_trim,
  output logic [CH_W-1:0]      out_throttle_trim,
  output logic [PCT_W-1:0]     limit_percent,
  output logic                 crawl_active,
  output logic                 battery_warning
);

  localparam int THR_W   = CH_W + Q_W + 2;
  localparam int PCT_P_W = Q_W + PCT_W;
  localparam int STR_P_W = CH_W + Q_W;

  // product stage
  logic                       a_valid;
  side_t                      a_side;
  logic signed [THR_W-1:0]    a_thr_prod;
  logic [PCT_P_W-1:0]         a_pct_prod;
  logic [STR_P_W-1:0]         a_steer_prod;

  logic signed [THR_W-1:0]    thr_prod_next;
  logic [PCT_P_W-1:0]         pct_prod_next;
  logic [STR_P_W-1:0]         steer_prod_next;

  always_comb begin
    logic [Q_W-1:0]        lim;
    logic signed [CH_W:0]  dev;
    case (side_in.mode)
      LIM_FULL: lim = Q16_ONE;
      LIM_DIV:  lim = {1'b0, div_in.quot};
      default:  lim = '0;
    endcase
    if (side_in.crawl && (lim > crawl_limit_q16)) lim = crawl_limit_q16;
    dev             = $signed({1'b0, side_in.throttle}) - $signed({1'b0, channel_center});
    thr_prod_next   = THR_W'(dev) * THR_W'($signed({1'b0, lim}));
    pct_prod_next   = PCT_P_W'(lim) * PCT_P_W'(PCT_SCALE);
    steer_prod_next = STR_P_W'(side_in.trim_mag) * STR_P_W'(trim_limit_q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    a_side       <= side_in;
    a_thr_prod   <= thr_prod_next;
    a_pct_prod   <= pct_prod_next;
    a_steer_prod <= steer_prod_next;
  end

  // output stage
  logic [CH_W-1:0]  steer_next;
  logic [CH_W-1:0]  throttle_next;
  logic [PCT_W-1:0] pct_next;

  always_comb begin
    logic signed [THR_W-Q_FRAC-1:0] thr_shift;
    logic signed [CH_W+3:0]         thr_v;
    logic [CH_W:0]                  steer_shift;
    logic signed [CH_W+3:0]         steer_v;
    logic [PCT_P_W-1:0]             pct_sum;
    thr_shift     = a_thr_prod[THR_W-1:Q_FRAC];
    thr_v         = $signed({4'b0000, channel_center}) + (CH_W+4)'(thr_shift);
    throttle_next = clamp_ch(thr_v, channel_min, channel_max);
    steer_shift   = a_steer_prod[STR_P_W-1:Q_FRAC];
    if (a_side.trim_neg) begin
      steer_v = $signed({4'b0000, a_side.steer}) - $signed({3'b000, steer_shift});
    end else begin
      steer_v = $signed({4'b0000, a_side.steer}) + $signed({3'b000, steer_shift});
    end
    steer_next = clamp_ch(steer_v, channel_min, channel_max);
    pct_sum    = a_pct_prod + PCT_ROUND;
    pct_next   = pct_sum[Q_FRAC+PCT_W-1:Q_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_steer         <= a_side.armed ? steer_next     : channel_center;
    out_throttle      <= a_side.armed ? throttle_next  : channel_center;
    out_arm           <= a_side.armed ? channel_max    : channel_min;
    out_steer_trim    <= a_side.armed ? a_side.s_trim  : channel_center;
    out_throttle_trim <= a_side.armed ? a_side.t_trim  : channel_center;
    limit_percent     <= pct_next;
    crawl_active      <= a_side.crawl;
    battery_warning   <= a_side.warn;
  end

  `RCTS_ASSERT_IMP(a_pct_range, clk, rst, done, limit_percent <= PCT_SCALE)

endmodule

`default_nettype wire

FILE: sv/rc_channel_trim_and_speed_limit.sv
// ----------------------------------------------------------------------------
// rc_channel_trim_and_speed_limit
// steering trim, throttle speed limit and arm gating for radio channel words
//
// usage:
//   an item (one frame of channel words, battery voltage and arm switch) is
//   taken at a rising edge with start high and busy low; busy is high only
//   during reset and in the cycle after it
//   the result shows on the out_* ports, limit_percent, crawl_active and
//   battery_warning for exactly one cycle, marked by done; the receiver
//   cannot hold it off
//   an item passes the front register, the divider stage registers (four
//   quotient bits per divider stage by default), the product register
//   and the output register before the result shows
//   throughput is one item per cycle while busy is low; the speed limit divider is unrolled
//   into register stages, so nothing in the path loops
//   registers are written through wr_en / wr_index / wr_data at any edge;
//   change them only while no item is in flight
//   reset loads the register defaults and drops every item in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc_channel_trim_and_speed_limit_assert.svh"

module rc_channel_trim_and_speed_limit import rcts_pkg::*; #(
  parameter int DIV_STAGE_BITS = DIV_STAGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CH_W-1:0]       steer_value,
  input  wire logic [CH_W-1:0]       throttle_value,
  input  wire logic [CH_W-1:0]       steer_trim,
  input  wire logic [CH_W-1:0]       throttle_trim,
  input  wire logic [MV_W-1:0]       battery_mv,
  input  wire logic                  arm_switch,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic                       done,
  output logic [CH_W-1:0]            out_steer,
  output logic [CH_W-1:0]            out_throttle,
  output logic [CH_W-1:0]            out_arm,
  output logic [CH_W-1:0]            out_steer_trim,
  output logic [CH_W-1:0]            out_throttle_trim,
  output logic [PCT_W-1:0]           limit_percent,
  output logic                       crawl_active,
  output logic                       battery_warning
);

  localparam int DIV_STAGES = Q_FRAC / DIV_STAGE_BITS;
  localparam int LATENCY    = DIV_STAGES + 3;

  logic [CH_W-1:0] channel_min;
  logic [CH_W-1:0] channel_center;
  logic [CH_W-1:0] channel_max;
  logic [MV_W-1:0] crawl_threshold_mv;
  logic [MV_W-1:0] warn_threshold_mv;
  logic [Q_W-1:0]  crawl_limit_q16;
  logic [Q_W-1:0]  trim_limit_q16;

  logic take;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_min        <= RST_CHANNEL_MIN;
      channel_center     <= RST_CHANNEL_CENTER;
      channel_max        <= RST_CHANNEL_MAX;
      crawl_threshold_mv <= RST_CRAWL_THRESH;
      warn_threshold_mv  <= RST_WARN_THRESH;
      crawl_limit_q16    <= RST_CRAWL_LIMIT;
      trim_limit_q16     <= RST_TRIM_LIMIT;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNEL_MIN:    channel_min        <= wr_data[CH_W-1:0];
        REG_CHANNEL_CENTER: channel_center     <= wr_data[CH_W-1:0];
        REG_CHANNEL_MAX:    channel_max        <= wr_data[CH_W-1:0];
        REG_CRAWL_THRESH:   crawl_threshold_mv <= wr_data[MV_W-1:0];
        REG_WARN_THRESH:    warn_threshold_mv  <= wr_data[MV_W-1:0];
        REG_CRAWL_LIMIT:    crawl_limit_q16    <= wr_data[Q_W-1:0];
        REG_TRIM_LIMIT:     trim_limit_q16     <= wr_data[Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic  stg_valid [DIV_STAGES+1];
  side_t stg_side  [DIV_STAGES+1];
  div_t  stg_div   [DIV_STAGES+1];

  rcts_front u_front (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .steer_value        (steer_value),
    .throttle_value     (throttle_value),
    .steer_trim         (steer_trim),
    .throttle_trim      (throttle_trim),
    .battery_mv         (battery_mv),
    .arm_switch         (arm_switch),
    .channel_min        (channel_min),
    .channel_center     (channel_center),
    .channel_max        (channel_max),
    .crawl_threshold_mv (crawl_threshold_mv),
    .warn_threshold_mv  (warn_threshold_mv),
    .valid              (stg_valid[0]),
    .side               (stg_side[0]),
    .div                (stg_div[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rcts_div_stage #(
      .STAGE_BITS (DIV_STAGE_BITS)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (stg_valid[g]),
      .side_in   (stg_side[g]),
      .div_in    (stg_div[g]),
      .valid_out (stg_valid[g+1]),
      .side_out  (stg_side[g+1]),
      .div_out   (stg_div[g+1])
    );
  end

  rcts_back u_back (
    .clk               (clk),
    .rst               (rst),
    .valid_in          (stg_valid[DIV_STAGES]),
    .side_in           (stg_side[DIV_STAGES]),
    .div_in            (stg_div[DIV_STAGES]),
    .channel_min       (channel_min),
    .channel_center    (channel_center),
    .channel_max       (channel_max),
    .crawl_limit_q16   (crawl_limit_q16),
    .trim_limit_q16    (trim_limit_q16),
    .done              (done),
    .out_steer         (out_steer),
    .out_throttle      (out_throttle),
    .out_arm           (out_arm),
    .out_steer_trim    (out_steer_trim),
    .out_throttle_trim (out_throttle_trim),
    .limit_percent     (limit_percent),
    .crawl_active      (crawl_active),
    .battery_warning   (battery_warning)
  );

  `RCTS_ASSERT_IMP(a_item_latency, clk, rst, take, ##LATENCY done)
  `RCTS_ASSERT_IMP(a_arm_word, clk, rst, done, (out_arm == channel_max) || (out_arm == channel_min))

endmodule

`default_nettype wire

FILE: tb/sv/rc_channel_trim_and_speed_limit_tb.sv
// ----------------------------------------------------------------------------
// rc_channel_trim_and_speed_limit_tb
// drives channel frames through the trim and speed limit pipeline under a
// series of register settings (reset values, wide and inverted ranges, flat
// ranges, junk upper bits) with random sender gaps, and checks every output
// word against an independent fixed point prediction of the frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_channel_trim_and_speed_limit_tb import rcts_pkg::*; ();

  typedef struct {
    logic [CH_W-1:0] steer;
    logic [CH_W-1:0] throttle;
    logic [CH_W-1:0] s_trim;
    logic [CH_W-1:0] t_trim;
    logic [MV_W-1:0] batt;
    logic            arm;
  } frame_t;

  typedef struct {
    logic [CH_W-1:0]  steer;
    logic [CH_W-1:0]  throttle;
    logic [CH_W-1:0]  arm;
    logic [CH_W-1:0]  s_trim;
    logic [CH_W-1:0]  t_trim;
    logic [PCT_W-1:0] pct;
    logic             crawl;
    logic             warn;
  } channels_t;

  class trim_scoreboard;
    longint ch_min, ch_center, ch_max, crawl_th, warn_th, crawl_lim, trim_lim;
    channels_t expected_q[$];
    string names[8];
    int errors, frames, checked, writes;

    function new();
      ch_min = longint'(RST_CHANNEL_MIN);
      ch_center = longint'(RST_CHANNEL_CENTER);
      ch_max = longint'(RST_CHANNEL_MAX);
      crawl_th = longint'(RST_CRAWL_THRESH);
      warn_th = longint'(RST_WARN_THRESH);
      crawl_lim = longint'(RST_CRAWL_LIMIT);
      trim_lim = longint'(RST_TRIM_LIMIT);
      names = '{"out_steer", "out_throttle", "out_arm", "out_steer_trim",
                "out_throttle_trim", "limit_percent", "crawl_active",
                "battery_warning"};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      writes++;
      case (idx)
        REG_CHANNEL_MIN:    ch_min = longint'(val[CH_W-1:0]);
        REG_CHANNEL_CENTER: ch_center = longint'(val[CH_W-1:0]);
        REG_CHANNEL_MAX:    ch_max = longint'(val[CH_W-1:0]);
        REG_CRAWL_THRESH:   crawl_th = longint'(val[MV_W-1:0]);
        REG_WARN_THRESH:    warn_th = longint'(val[MV_W-1:0]);
        REG_CRAWL_LIMIT:    crawl_lim = longint'(val[Q_W-1:0]);
        REG_TRIM_LIMIT:     trim_lim = longint'(val[Q_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint v);
      if (v < ch_min) v = ch_min;
      if (v > ch_max) v = ch_max;
      return v;
    endfunction

    function channels_t channel_words(frame_t f);
      channels_t r;
      longint span, d, mag, shift, lim, dev, steer_w, throt_w;
      bit crawl, warn;
      span = ch_max - ch_center;
      shift = 0;
      if (span > 0) begin
        d = longint'(f.s_trim) - ch_center;
        if (d > span) d = span;
        if (d < -span) d = -span;
        mag = ((d < 0 ? -d : d) * trim_lim) >> 16;
        shift = d < 0 ? -mag : mag;
      end
      steer_w = clamp_word(longint'(f.steer) + shift);

      span = ch_max - ch_min;
      d = longint'(f.t_trim) - ch_min;
      if (span <= 0) lim = d >= 0 ? 65536 : 0;
      else if (d <= 0) lim = 0;
      else begin
        lim = (d * 65536) / span;
        if (lim > 65536) lim = 65536;
      end
      crawl = f.batt != 0 && f.batt < crawl_th;
      warn = f.batt != 0 && f.batt < warn_th;
      if (crawl && lim > crawl_lim) lim = crawl_lim;
      dev = longint'(f.throttle) - ch_center;
      throt_w = clamp_word(ch_center + ((dev * lim) >>> 16));

      r.steer = f.arm ? steer_w[CH_W-1:0] : ch_center[CH_W-1:0];
      r.throttle = f.arm ? throt_w[CH_W-1:0] : ch_center[CH_W-1:0];
      r.arm = f.arm ? ch_max[CH_W-1:0] : ch_min[CH_W-1:0];
      r.s_trim = f.arm ? f.s_trim : ch_center[CH_W-1:0];
      r.t_trim = f.arm ? f.t_trim : ch_center[CH_W-1:0];
      lim = (lim * 100 + 32768) >> 16;
      r.pct = lim[PCT_W-1:0];
      r.crawl = crawl;
      r.warn = warn;
      return r;
    endfunction

    function void note_frame(frame_t f);
      frames++;
      expected_q.push_back(channel_words(f));
    endfunction

    function void check_result(channels_t act);
      channels_t e;
      logic [CH_W-1:0] ev[8], av[8];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result, nothing pending: out_steer %0d", $time, act.steer);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      ev = '{e.steer, e.throttle, e.arm, e.s_trim, e.t_trim, CH_W'(e.pct),
             CH_W'(e.crawl), CH_W'(e.warn)};
      av = '{act.steer, act.throttle, act.arm, act.s_trim, act.t_trim, CH_W'(act.pct),
             CH_W'(act.crawl), CH_W'(act.warn)};
      for (int i = 0; i < 8; i++) begin
        if (ev[i] !== av[i]) begin
          errors++;
          if (errors <= 60)
            $display("%0t mismatch %s: expected %0d actual %0d", $time, names[i], ev[i], av[i]);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flush_leftover();
      $display("%0t %0d expected results never arrived", $time, expected_q.size());
      errors += expected_q.size();
      expected_q.delete();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CH_W-1:0]       steer_value = '0;
  logic [CH_W-1:0]       throttle_value = '0;
  logic [CH_W-1:0]       steer_trim = '0;
  logic [CH_W-1:0]       throttle_trim = '0;
  logic [MV_W-1:0]       battery_mv = '0;
  logic                  arm_switch = 1'b0;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  done;
  logic [CH_W-1:0]       out_steer;
  logic [CH_W-1:0]       out_throttle;
  logic [CH_W-1:0]       out_arm;
  logic [CH_W-1:0]       out_steer_trim;
  logic [CH_W-1:0]       out_throttle_trim;
  logic [PCT_W-1:0]      limit_percent;
  logic                  crawl_active;
  logic                  battery_warning;

  trim_scoreboard sb = new();
  int settings_run = 0;

  rc_channel_trim_and_speed_limit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .steer_value(steer_value),
    .throttle_value(throttle_value),
    .steer_trim(steer_trim),
    .throttle_trim(throttle_trim),
    .battery_mv(battery_mv),
    .arm_switch(arm_switch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .out_steer(out_steer),
    .out_throttle(out_throttle),
    .out_arm(out_arm),
    .out_steer_trim(out_steer_trim),
    .out_throttle_trim(out_throttle_trim),
    .limit_percent(limit_percent),
    .crawl_active(crawl_active),
    .battery_warning(battery_warning)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    frame_t f;
    channels_t c;
    if (!rst) begin
      if (done === 1'b1) begin
        c = '{out_steer, out_throttle, out_arm, out_steer_trim, out_throttle_trim,
              limit_percent, crawl_active, battery_warning};
        sb.check_result(c);
      end
      if (wr_en) sb.set_reg(wr_index, wr_data);
      if (start && busy === 1'b0) begin
        f = '{steer_value, throttle_value, steer_trim, throttle_trim, battery_mv, arm_switch};
        sb.note_frame(f);
      end
    end
  end

  function automatic frame_t mk(int steer, int throt, int s_trim, int t_trim, int batt,
                                int arm);
    frame_t f;
    f = '{CH_W'(steer), CH_W'(throt), CH_W'(s_trim), CH_W'(t_trim), MV_W'(batt), arm[0]};
    return f;
  endfunction

  function automatic logic [CH_W-1:0] pick_word();
    int v, off;
    off = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      5: v = int'(sb.ch_min) + off - 8;
      6: v = int'(sb.ch_center) + off - 8;
      7: v = int'(sb.ch_max) + off - 8;
      8: v = 0;
      9: v = 2047;
      default: v = $urandom_range(0, 2047);
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v[CH_W-1:0];
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int b, off;
    off = $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      4: b = 0;
      5, 6: b = int'(sb.crawl_th) + off - 4;
      7, 8: b = int'(sb.warn_th) + off - 4;
      9: b = $urandom_range(0, 1) ? 65535 : 1;
      default: b = $urandom_range(0, 65535);
    endcase
    if (b < 0) b = 0;
    if (b > 65535) b = 65535;
    f.steer = pick_word();
    f.throttle = pick_word();
    f.s_trim = pick_word();
    f.t_trim = pick_word();
    f.batt = b[MV_W-1:0];
    f.arm = $urandom_range(0, 4) != 0;
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    steer_value <= f.steer;
    throttle_value <= f.throttle;
    steer_trim <= f.s_trim;
    throttle_trim <= f.t_trim;
    battery_mv <= f.batt;
    arm_switch <= f.arm;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    int n;
    start <= 1'b0;
    @(posedge clk);
    n = 0;
    while (sb.pending() != 0 && n < 200) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() != 0) sb.flush_leftover();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic load_settings(input int mn, input int ctr, input int mx, input int crawl_mv,
                               input int warn_mv, input int crawl_q, input int trim_q);
    drain();
    write_reg(REG_CHANNEL_MIN, mn);
    write_reg(REG_CHANNEL_CENTER, ctr);
    write_reg(REG_CHANNEL_MAX, mx);
    write_reg(REG_CRAWL_THRESH, crawl_mv);
    write_reg(REG_WARN_THRESH, warn_mv);
    write_reg(REG_CRAWL_LIMIT, crawl_q);
    write_reg(REG_TRIM_LIMIT, trim_q);
    wr_en <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  task automatic run_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) send_frame(rand_frame(), idle_pct);
  endtask

  initial begin
    frame_t directed[$];
    int lo, ctr;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    directed = '{mk(992, 992, 992, 992, 0, 1), mk(0, 0, 0, 0, 0, 1),
                 mk(2047, 2047, 2047, 2047, 65535, 1), mk(1500, 2047, 2047, 2047, 8000, 1),
                 mk(500, 0, 0, 1811, 8000, 1), mk(992, 1500, 992, 172, 8000, 1),
                 mk(992, 1500, 992, 1000, 8000, 1), mk(992, 400, 992, 1500, 5999, 1),
                 mk(992, 400, 992, 1500, 6000, 1), mk(992, 400, 992, 1500, 6999, 1),
                 mk(992, 400, 992, 1500, 7000, 1), mk(992, 1600, 992, 1500, 1, 1),
                 mk(992, 1600, 992, 1500, 0, 1), mk(992, 1600, 992, 100, 3000, 1),
                 mk(1811, 1811, 1811, 1811, 65535, 1), mk(172, 172, 172, 172, 65535, 1),
                 mk(1200, 300, 1800, 900, 5000, 0), mk(0, 2047, 0, 2047, 0, 0),
                 mk(2047, 0, 2047, 0, 1, 0), mk(993, 991, 993, 991, 12345, 1),
                 mk(1400, 1300, 1024, 1400, 0, 1), mk(1, 2046, 1365, 682, 43690, 1),
                 mk(1365, 682, 682, 1365, 21845, 1)};
    foreach (directed[i]) send_frame(directed[i], 0);
    run_random(190, 0);

    lo = $urandom_range(0, 600);
    ctr = lo + $urandom_range(1, 700);
    load_settings(lo, ctr, ctr + $urandom_range(1, 2047 - ctr), $urandom_range(0, 12000),
                  $urandom_range(0, 12000), $urandom_range(0, 65536), $urandom_range(0, 65536));
    run_random(190, 60);

    // widest range, thresholds at the top
    load_settings(0, 1024, 2047, 65535, 65535, 0, 65536);
    run_random(190, 13);

    // inverted range and oversized fractions
    load_settings(2047, 2047, 0, 0, 0, 131071, 131071);
    run_random(190, 0);

    // no span at all
    load_settings(1000, 1000, 1000, 7000, 6000, 65536, 65535);
    run_random(190, 60);

    // junk in the unused upper bits
    load_settings($urandom_range(0, 131071), $urandom_range(0, 131071),
                  $urandom_range(0, 131071), $urandom_range(0, 131071),
                  $urandom_range(0, 131071), $urandom_range(0, 131071),
                  $urandom_range(0, 131071));
    run_random(190, 13);

    // center below min
    load_settings(900, 100, 1900, 65535, 1, 65537, 131071);
    run_random(190, 0);

    load_settings(int'(RST_CHANNEL_MIN), int'(RST_CHANNEL_CENTER), int'(RST_CHANNEL_MAX),
                  int'(RST_CRAWL_THRESH), int'(RST_WARN_THRESH), int'(RST_CRAWL_LIMIT),
                  int'(RST_TRIM_LIMIT));
    run_random(190, 60);

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.flush_leftover();

    $display("covered %0d frames and %0d checked results over %0d register settings",
             sb.frames, sb.checked, settings_run + 1);
    $display("%0d register writes, %0d field errors", sb.writes, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", sb.pending());
    $display("FAIL");
    $finish;
  end

endmodule

FILE: rc_channel_trim_and_speed_limit.f
+incdir+sv
sv/rcts_pkg.sv
sv/rcts_front.sv
sv/rcts_div_stage.sv
sv/rcts_back.sv
sv/rc_channel_trim_and_speed_limit.sv
tb/sv/rc_channel_trim_and_speed_limit_tb.sv
